@@ hw/rtl/erx_pkg.sv @@
// ----------------------------------------------------------------------------
// erx_pkg: shared types and constants of the eight-bit execute unit
// Opcode codes, flag bit positions, field widths and the result record.
// ----------------------------------------------------------------------------
package erx_pkg;

    localparam int INSTR_W = 16;
    localparam int PC_W    = 16;
    localparam int DATA_W  = 8;
    localparam int RIDX_W  = 6;
    localparam int FLAGS_W = 5;
    localparam int ADDR_ENTRIES = 2 ** RIDX_W;

    // Flag bit positions in the status word.
    localparam int FLAG_C = 4;
    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_Z = 0;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_LDI  = 4'd3,
        OP_BEQZ = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_JR   = 4'd7,
        OP_SLC  = 4'd8,
        OP_SRC  = 4'd9,
        OP_LB   = 4'd10,
        OP_SB   = 4'd11
    } op_t;

    typedef struct packed {
        logic [PC_W-1:0]    new_pc;
        logic               redirect;
        logic               reg_written;
        logic [RIDX_W-1:0]  dest_reg;
        logic [DATA_W-1:0]  write_value;
        logic               mem_written;
        logic [FLAGS_W-1:0] status_flags;
        logic               bad_opcode;
    } res_t;

endpackage

@@ hw/rtl/erx_if.sv @@
// ----------------------------------------------------------------------------
// erx_if: channel interfaces of the execute unit
// Instruction channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface erx_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;
    logic [15:0] next_pc;

    modport source (output valid, output instruction, output next_pc, input ready);
    modport sink   (input valid, input instruction, input next_pc, output ready);
endinterface

interface erx_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_pc;
    logic        redirect;
    logic        reg_written;
    logic [5:0]  dest_reg;
    logic [7:0]  write_value;
    logic        mem_written;
    logic [4:0]  status_flags;
    logic        bad_opcode;

    modport source (output valid, output new_pc, output redirect, output reg_written,
                    output dest_reg, output write_value, output mem_written,
                    output status_flags, output bad_opcode, input ready);
    modport sink   (input valid, input new_pc, input redirect, input reg_written,
                    input dest_reg, input write_value, input mem_written,
                    input status_flags, input bad_opcode, output ready);
endinterface

@@ hw/rtl/erx_regfile.sv @@
// ----------------------------------------------------------------------------
// erx_regfile: general register file
// Two registered read ports, one write port, per-entry valid bits so that
// unwritten registers read as zero, and a same-edge write bypass.
// ----------------------------------------------------------------------------
module erx_regfile #(
    parameter int REG_COUNT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [erx_pkg::RIDX_W-1:0] rd_addr_a,
    input  logic [erx_pkg::RIDX_W-1:0] rd_addr_b,
    input  logic                        wr_en,
    input  logic [erx_pkg::RIDX_W-1:0] wr_addr,
    input  logic [erx_pkg::DATA_W-1:0] wr_data,
    output logic [erx_pkg::DATA_W-1:0] rd_data_a,
    output logic [erx_pkg::DATA_W-1:0] rd_data_b
);

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [erx_pkg::RIDX_W:0] LIMIT = (erx_pkg::RIDX_W + 1)'(REG_COUNT);

    logic [erx_pkg::DATA_W-1:0] store_reg [REG_COUNT];
    logic [REG_COUNT-1:0]       valid_reg;

    logic                       in_a, in_b;
    logic [AW-1:0]              idx_a, idx_b, wr_idx;
    logic [erx_pkg::DATA_W-1:0] data_a_reg, data_b_reg;
    logic [erx_pkg::DATA_W-1:0] byp_data_a_reg, byp_data_b_reg;
    logic                       hit_a_reg, hit_b_reg, byp_a_reg, byp_b_reg;

    assign in_a   = {1'b0, rd_addr_a} < LIMIT;
    assign in_b   = {1'b0, rd_addr_b} < LIMIT;
    assign idx_a  = in_a ? rd_addr_a[AW-1:0] : '0;
    assign idx_b  = in_b ? rd_addr_b[AW-1:0] : '0;
    assign wr_idx = wr_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg     <= store_reg[idx_a];
            data_b_reg     <= store_reg[idx_b];
            byp_data_a_reg <= wr_data;
            byp_data_b_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= in_a && valid_reg[idx_a];
                hit_b_reg <= in_b && valid_reg[idx_b];
                // A write on the same edge as the read is not yet in the array.
                byp_a_reg <= wr_en && in_a && (wr_addr == rd_addr_a);
                byp_b_reg <= wr_en && in_b && (wr_addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = byp_a_reg ? byp_data_a_reg : (hit_a_reg ? data_a_reg : '0);
    assign rd_data_b = byp_b_reg ? byp_data_b_reg : (hit_b_reg ? data_b_reg : '0);

endmodule

@@ hw/rtl/erx_dstore.sv @@
// ----------------------------------------------------------------------------
// erx_dstore: data store
// One registered read port and one write port. Only the low 64 entries are
// reachable by the 6-bit address, so those carry valid bits for reset.
// ----------------------------------------------------------------------------
module erx_dstore #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [erx_pkg::RIDX_W-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [erx_pkg::RIDX_W-1:0] wr_addr,
    input  logic [erx_pkg::DATA_W-1:0] wr_data,
    output logic [erx_pkg::DATA_W-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [erx_pkg::DATA_W-1:0]        store_reg [DEPTH];
    logic [erx_pkg::ADDR_ENTRIES-1:0]  valid_reg;
    logic [AW-1:0]                     rd_idx, wr_idx;
    logic [erx_pkg::DATA_W-1:0]        data_reg, byp_data_reg;
    logic                              hit_reg, byp_reg;

    assign rd_idx = AW'(rd_addr);
    assign wr_idx = AW'(wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg     <= store_reg[rd_idx];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
                byp_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : (hit_reg ? data_reg : '0);

endmodule

@@ hw/rtl/erx_exec.sv @@
// ----------------------------------------------------------------------------
// erx_exec: instruction execute logic
// Decodes one instruction with its operands and forms the result record,
// including the next flag word and the write controls.
// ----------------------------------------------------------------------------
module erx_exec (
    input  logic [erx_pkg::INSTR_W-1:0] instruction,
    input  logic [erx_pkg::PC_W-1:0]    next_pc,
    input  logic [erx_pkg::DATA_W-1:0]  v1,
    input  logic [erx_pkg::DATA_W-1:0]  v2,
    input  logic [erx_pkg::DATA_W-1:0]  load_data,
    input  logic [erx_pkg::FLAGS_W-1:0] flags,
    input  logic                        ra_ok,
    output erx_pkg::res_t               result
);

    erx_pkg::op_t               op;
    logic [erx_pkg::RIDX_W-1:0] ra, rb;
    logic [erx_pkg::DATA_W-1:0] imm8, addend, val, sum8;
    logic [erx_pkg::PC_W-1:0]   imm16;
    logic [erx_pkg::DATA_W:0]   sum9;
    logic [15:0]                product, rot_wide;
    logic [2:0]                 rot_amt;
    logic                       wreg, wmem, ovf;
    logic [erx_pkg::FLAGS_W-1:0] flags_next, nz_flags;

    assign op    = erx_pkg::op_t'(instruction[15:12]);
    assign ra    = instruction[11:6];
    assign rb    = instruction[5:0];
    assign imm8  = {{2{rb[5]}}, rb};
    assign imm16 = {{10{rb[5]}}, rb};

    // SUB adds the two's complement of the second operand.
    assign addend  = (op == erx_pkg::OP_SUB) ? (8'd0 - v2) : v2;
    assign sum9    = {1'b0, v1} + {1'b0, addend};
    assign sum8    = sum9[7:0];
    assign ovf     = (v1[7] == addend[7]) && (sum8[7] != v1[7]);
    assign product = v1 * v2;

    // Right rotation is a left rotation by the complementary amount.
    assign rot_amt  = (op == erx_pkg::OP_SRC) ? (3'd0 - rb[2:0]) : rb[2:0];
    assign rot_wide = {v1, v1} << rot_amt;

    always_comb
    begin
        val = '0;
        case (op)
            erx_pkg::OP_MUL: val = product[7:0];
            erx_pkg::OP_AND: val = v1 & v2;
            erx_pkg::OP_OR:  val = v1 | v2;
            default:         val = rot_wide[15:8];
        endcase
    end

    always_comb
    begin
        nz_flags = flags;
        nz_flags[erx_pkg::FLAG_N] = val[7];
        nz_flags[erx_pkg::FLAG_Z] = (val == '0);
    end

    always_comb
    begin
        result     = '0;
        result.new_pc = next_pc;
        flags_next = flags;
        wreg       = 1'b0;
        wmem       = 1'b0;
        case (op)
            erx_pkg::OP_ADD, erx_pkg::OP_SUB:
            begin
                result.write_value = sum8;
                flags_next = {sum9[8], ovf, sum8[7], sum8[7] ^ ovf, sum8 == '0};
                wreg = 1'b1;
            end
            erx_pkg::OP_MUL, erx_pkg::OP_AND, erx_pkg::OP_OR,
            erx_pkg::OP_SLC, erx_pkg::OP_SRC:
            begin
                result.write_value = val;
                flags_next = nz_flags;
                wreg = 1'b1;
            end
            erx_pkg::OP_LDI:
            begin
                result.write_value = imm8;
                wreg = 1'b1;
            end
            erx_pkg::OP_BEQZ:
            begin
                if (v1 == '0)
                begin
                    result.new_pc   = next_pc + imm16;
                    result.redirect = 1'b1;
                end
            end
            erx_pkg::OP_JR:
            begin
                result.new_pc   = {v1, v2};
                result.redirect = 1'b1;
            end
            erx_pkg::OP_LB:
            begin
                result.write_value = load_data;
                wreg = 1'b1;
            end
            erx_pkg::OP_SB:
            begin
                result.write_value = v1;
                wmem = 1'b1;
            end
            default:
            begin
                result.bad_opcode = 1'b1;
            end
        endcase

        // Writes to a register beyond the file are dropped.
        if (wreg && !ra_ok)
        begin
            wreg = 1'b0;
            result.write_value = '0;
        end
        result.reg_written  = wreg;
        result.dest_reg     = wreg ? ra : '0;
        result.mem_written  = wmem;
        result.status_flags = flags_next;
    end

endmodule

@@ hw/rtl/eight_bit_risc_execute_unit.sv @@
// ----------------------------------------------------------------------------
// eight_bit_risc_execute_unit: execute stage of an eight-bit RISC datapath
// Reads operands from the register file and data store, executes, writes back.
// ----------------------------------------------------------------------------
//  Channel   Role     Payload
//  cmd       sink     instruction, next_pc
//  res       source   new_pc, redirect, reg_written, dest_reg, write_value,
//                     mem_written, status_flags, bad_opcode
//
// One instruction per cycle while results are taken; the register file and
// data store are read as it transfers in, and its result is registered out.
// Writes land as an instruction leaves execute; a same-edge bypass in each
// memory hands that value to the instruction read on that edge.
// Reset clears all registers and the data store at once through valid bits.
// A stalled result holds execute; the input side stalls only when both fill.
// ----------------------------------------------------------------------------
module eight_bit_risc_execute_unit #(
    parameter int REG_COUNT  = 64,
    parameter int DATA_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    erx_cmd_if.sink          cmd,
    erx_res_if.source        res
);

    localparam logic [erx_pkg::RIDX_W:0] REG_LIMIT = (erx_pkg::RIDX_W + 1)'(REG_COUNT);

    logic                         s1_v_reg, s1_v_next;
    logic                         out_v_reg, out_v_next;
    logic [erx_pkg::INSTR_W-1:0]  s1_instr_reg;
    logic [erx_pkg::PC_W-1:0]     s1_npc_reg;
    logic [erx_pkg::FLAGS_W-1:0]  flag_reg;
    erx_pkg::res_t                out_res_reg;
    erx_pkg::res_t                exe;

    logic                         accept, s1_adv, retire, ra_ok;
    logic [erx_pkg::DATA_W-1:0]   v1, v2, load_data;

    assign s1_adv    = !out_v_reg || res.ready;
    assign cmd.ready = !s1_v_reg || s1_adv;
    assign accept    = cmd.valid && cmd.ready;
    assign retire    = s1_v_reg && s1_adv;
    assign ra_ok     = {1'b0, s1_instr_reg[11:6]} < REG_LIMIT;

    erx_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (cmd.instruction[11:6]),
        .rd_addr_b (cmd.instruction[5:0]),
        .wr_en     (retire && exe.reg_written),
        .wr_addr   (exe.dest_reg),
        .wr_data   (exe.write_value),
        .rd_data_a (v1),
        .rd_data_b (v2)
    );

    erx_dstore #(
        .DEPTH (DATA_DEPTH)
    ) u_dstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cmd.instruction[5:0]),
        .wr_en   (retire && exe.mem_written),
        .wr_addr (s1_instr_reg[5:0]),
        .wr_data (exe.write_value),
        .rd_data (load_data)
    );

    erx_exec u_exec (
        .instruction (s1_instr_reg),
        .next_pc     (s1_npc_reg),
        .v1          (v1),
        .v2          (v2),
        .load_data   (load_data),
        .flags       (flag_reg),
        .ra_ok       (ra_ok),
        .result      (exe)
    );

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (accept)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_v_next = 1'b0;
        end

        out_v_next = out_v_reg;
        if (retire)
        begin
            out_v_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            flag_reg  <= '0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
            if (retire)
            begin
                flag_reg <= exe.status_flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= cmd.instruction;
            s1_npc_reg   <= cmd.next_pc;
        end
        if (retire)
        begin
            out_res_reg <= exe;
        end
    end

    assign res.valid        = out_v_reg;
    assign res.new_pc       = out_res_reg.new_pc;
    assign res.redirect     = out_res_reg.redirect;
    assign res.reg_written  = out_res_reg.reg_written;
    assign res.dest_reg     = out_res_reg.dest_reg;
    assign res.write_value  = out_res_reg.write_value;
    assign res.mem_written  = out_res_reg.mem_written;
    assign res.status_flags = out_res_reg.status_flags;
    assign res.bad_opcode   = out_res_reg.bad_opcode;

`ifndef ASSERT_OFF
    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> cmd.ready)
        else $error("input stalled with an empty output register");

    a_bad_opcode_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        retire && exe.bad_opcode |-> !exe.reg_written && !exe.mem_written && !exe.redirect)
        else $error("invalid opcode produced a side effect");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !retire |=> $stable(flag_reg))
        else $error("flags changed without a retiring instruction");

    a_dest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.reg_written |-> ({1'b0, res.dest_reg} < REG_LIMIT))
        else $error("register write reported beyond the register file");
`endif

endmodule
